FILE: rtl/pid_backcalc_antiwindup_core_macros.svh
// Assertion macros for the PID back-calculation core checker.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef PID_BACKCALC_ANTIWINDUP_CORE_MACROS_SVH
`define PID_BACKCALC_ANTIWINDUP_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define PBAW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define PBAW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pbaw_pkg.sv
// Shared constants and saturation helpers for the PID back-calculation core.
// No dependencies; used by the multiplier, divider and top level.
package pbaw_pkg;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Configuration register indexes
  localparam logic [2:0] REG_GAIN_P         = 3'd0;
  localparam logic [2:0] REG_GAIN_I         = 3'd1;
  localparam logic [2:0] REG_GAIN_D         = 3'd2;
  localparam logic [2:0] REG_GAIN_BACKCALC  = 3'd3;
  localparam logic [2:0] REG_INTEGRAL_BOUND = 3'd4;
  localparam logic [2:0] REG_OUTPUT_BOUND   = 3'd5;
  localparam logic [2:0] REG_ERROR_GATE     = 3'd6;
  localparam logic [2:0] REG_LOOP_ENABLE    = 3'd7;

  // Sign-extend a 32-bit value to the 35-bit working width
  function automatic logic signed [34:0] sx35(input logic signed [31:0] x);
    sx35 = {{3{x[31]}}, x};
  endfunction

  // Saturate a 35-bit signed value to 32 bits
  function automatic logic signed [31:0] sat_s32(input logic signed [34:0] x);
    logic [3:0] top;
    top = x[34:31];
    if ((top == 4'b0000) || (top == 4'b1111)) begin
      sat_s32 = x[31:0];
    end else if (x[34]) begin
      sat_s32 = S32_MIN;
    end else begin
      sat_s32 = S32_MAX;
    end
  endfunction

endpackage

FILE: rtl/pbaw_mul.sv
// Shared Q16.16 multiplier: registered 32x32 product, then floor shift and saturate.
// Depends on pbaw_pkg. The product and then the scaled result are each registered.
module pbaw_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [31:0] res
);
  import pbaw_pkg::*;

  logic signed [63:0] prod_r;
  logic               stage_r;
  logic               done_r;
  logic signed [31:0] res_r;
  logic signed [31:0] res_nxt;
  logic [16:0]        hi;

  // Floor shift by 16 is a plain bit-select; saturate when the top bits disagree
  always_comb begin
    hi = prod_r[63:47];
    if ((&hi) || !(|hi)) begin
      res_nxt = prod_r[47:16];
    end else if (prod_r[63]) begin
      res_nxt = S32_MIN;
    end else begin
      res_nxt = S32_MAX;
    end
  end

  // Hold the product, then the scaled result
  always_ff @(posedge clk) begin
    prod_r <= a * b;
    res_r  <= res_nxt;
  end

  // Track the two-stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= go;
      done_r  <= stage_r;
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: rtl/pbaw_div.sv
// Serial restoring divider for the derivative term: (num * 2^16) / dvs,
// truncated toward zero and saturated to 32 bits. Depends on pbaw_pkg.
module pbaw_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [31:0] num,
  input  logic [30:0]        dvs,
  output logic               done,
  output logic signed [31:0] quo
);
  import pbaw_pkg::*;

  logic               busy_r;
  logic               fin_r;
  logic               done_r;
  logic [4:0]         cnt_r;
  logic [30:0]        rem_r;
  logic [31:0]        sh_r;
  logic               neg_r;
  logic signed [31:0] quo_r;

  logic [31:0] mag;
  logic        ovf;
  logic [32:0] trial;
  logic [31:0] neg_q;

  // Magnitude of the numerator and early overflow test on its upper half
  always_comb begin
    mag   = num[31] ? (32'd0 - num) : num;
    ovf   = ({15'd0, mag[31:16]} >= dvs);
    trial = {1'b0, rem_r, sh_r[31]} - {2'b00, dvs};
    neg_q = 32'd0 - sh_r;
  end

  // Control: start (or flag done directly on overflow), one quotient bit a cycle, then a finishing step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (go) begin
        cnt_r <= 5'd0;
        if (ovf) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: remainder, shifting dividend/quotient and final saturation
  always_ff @(posedge clk) begin
    if (go) begin
      neg_r <= num[31];
      rem_r <= {15'd0, mag[31:16]};
      sh_r  <= {mag[15:0], 16'd0};
      if (ovf) begin
        quo_r <= num[31] ? S32_MIN : S32_MAX;
      end
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_r <= trial[30:0];
      end else begin
        rem_r <= {rem_r[29:0], sh_r[31]};
      end
      sh_r <= {sh_r[30:0], !trial[32]};
    end else if (fin_r) begin
      if (neg_r) begin
        quo_r <= (sh_r > 32'h8000_0000) ? S32_MIN : neg_q;
      end else begin
        quo_r <= sh_r[31] ? S32_MAX : sh_r;
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: rtl/pid_backcalc_antiwindup_core.sv
// PID controller with back-calculation anti-windup, signed Q16.16.
// Depends on pbaw_pkg, pbaw_mul and pbaw_div.
// Input channel in_*: one item per control step; in_tdata holds measured,
// target and time_step. Result channel out_*: drive in out_tdata, the gate
// flag in out_tuser. Configuration channel cfg_*: index and data, always ready.
// One item takes six passes through the shared multiplier and, with a non-zero
// time step, one pass through the serial divider. A zero time step skips the
// divider; an item stopped by the error gate skips the multiplier and the
// divider and goes straight to the output register. in_tready is high
// only while no item is in flight. A finished result waits in the output
// register; a new item is accepted meanwhile and the block stalls only at its
// end if that result has still not been taken. Synchronous reset clears the
// gains and bounds to zero, sets loop_enable, and zeroes the integral and the
// previous error. No configuration writes while an item is in flight.
module pid_backcalc_antiwindup_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // [31:0] measured, [63:32] target, [94:64] time_step
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] drive
  output logic        out_tuser,  // [0] gated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import pbaw_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ERR    = 4'd1;
  localparam logic [3:0] ST_GATE   = 4'd2;
  localparam logic [3:0] ST_MISSUE = 4'd3;
  localparam logic [3:0] ST_MWAIT  = 4'd4;
  localparam logic [3:0] ST_DSTART = 4'd5;
  localparam logic [3:0] ST_DWAIT  = 4'd6;
  localparam logic [3:0] ST_SUM    = 4'd7;
  localparam logic [3:0] ST_CLAMP  = 4'd8;
  localparam logic [3:0] ST_DIFF   = 4'd9;
  localparam logic [3:0] ST_OUT    = 4'd10;

  localparam logic [2:0] OP_P  = 3'd0;
  localparam logic [2:0] OP_I1 = 3'd1;
  localparam logic [2:0] OP_I2 = 3'd2;
  localparam logic [2:0] OP_D  = 3'd3;
  localparam logic [2:0] OP_C1 = 3'd4;
  localparam logic [2:0] OP_C2 = 3'd5;

  // Configuration registers
  logic signed [31:0] gain_p_r, gain_i_r, gain_d_r, gain_bc_r;
  logic [30:0]        ibound_r, obound_r, gate_r;
  logic               enable_r;

  // Control and loop state
  logic [3:0] state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [31:0] prev_r, prev_nxt;

  // Working registers
  logic signed [31:0] meas_r, meas_nxt, tgt_r, tgt_nxt;
  logic [30:0]        dt_r, dt_nxt;
  logic signed [31:0] err_r, err_nxt, diff_r, diff_nxt;
  logic signed [31:0] pterm_r, pterm_nxt, tmp_r, tmp_nxt;
  logic signed [31:0] iacc_r, iacc_nxt, num_r, num_nxt;
  logic signed [31:0] dterm_r, dterm_nxt, drv_r, drv_nxt;
  logic signed [34:0] sum_r, sum_nxt;
  logic               gated_r, gated_nxt;
  logic signed [31:0] out_drive_r, out_drive_nxt;
  logic               out_gated_r, out_gated_nxt;

  // Shared unit hookup
  logic               mul_go, mul_done;
  logic signed [31:0] mul_a, mul_b, mul_res;
  logic               div_go, div_done;
  logic signed [31:0] div_q;

  logic [32:0] err_mag;
  logic        gate_hit;
  logic signed [34:0] sum_clamped, iacc_clamped;

  // Clamp to a symmetric magnitude bound
  function automatic logic signed [34:0] clamp_mag(input logic signed [34:0] x,
                                                   input logic [30:0] bound);
    logic signed [34:0] bnd;
    bnd = {4'd0, bound};
    if (x > bnd) begin
      clamp_mag = bnd;
    end else if (x < -bnd) begin
      clamp_mag = -bnd;
    end else begin
      clamp_mag = x;
    end
  endfunction

  pbaw_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  pbaw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (num_r),
    .dvs   (dt_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // Select multiplier operands for the current pass
  always_comb begin
    case (op_r)
      OP_P: begin
        mul_a = gain_p_r;
        mul_b = err_r;
      end
      OP_I1: begin
        mul_a = gain_i_r;
        mul_b = err_r;
      end
      OP_I2: begin
        mul_a = tmp_r;
        mul_b = {1'b0, dt_r};
      end
      OP_D: begin
        mul_a = gain_d_r;
        mul_b = diff_r;
      end
      OP_C1: begin
        mul_a = tmp_r;
        mul_b = gain_bc_r;
      end
      OP_C2: begin
        mul_a = tmp_r;
        mul_b = {1'b0, dt_r};
      end
      default: begin
        mul_a = gain_p_r;
        mul_b = err_r;
      end
    endcase
  end

  // Gate test and clamps
  always_comb begin
    err_mag      = err_r[31] ? (33'd0 - {err_r[31], err_r}) : {1'b0, err_r};
    gate_hit     = (gate_r != 31'd0) && (err_mag > {2'b00, gate_r});
    sum_clamped  = clamp_mag(sum_r, obound_r);
    iacc_clamped = clamp_mag(sx35(iacc_r), ibound_r);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r;
    acc_nxt       = acc_r;
    prev_nxt      = prev_r;
    meas_nxt      = meas_r;
    tgt_nxt       = tgt_r;
    dt_nxt        = dt_r;
    err_nxt       = err_r;
    diff_nxt      = diff_r;
    pterm_nxt     = pterm_r;
    tmp_nxt       = tmp_r;
    iacc_nxt      = iacc_r;
    num_nxt       = num_r;
    dterm_nxt     = dterm_r;
    drv_nxt       = drv_r;
    sum_nxt       = sum_r;
    gated_nxt     = gated_r;
    out_drive_nxt = out_drive_r;
    out_gated_nxt = out_gated_r;
    mul_go        = 1'b0;
    div_go        = 1'b0;

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          meas_nxt  = in_tdata[31:0];
          tgt_nxt   = in_tdata[63:32];
          dt_nxt    = in_tdata[94:64];
          state_nxt = ST_ERR;
        end
      end
      ST_ERR: begin
        err_nxt   = sat_s32(sx35(tgt_r) - sx35(meas_r));
        state_nxt = ST_GATE;
      end
      ST_GATE: begin
        gated_nxt = gate_hit;
        diff_nxt  = sat_s32(sx35(err_r) - sx35(prev_r));
        op_nxt    = OP_P;
        state_nxt = gate_hit ? ST_OUT : ST_MISSUE;
      end
      ST_MISSUE: begin
        mul_go    = 1'b1;
        state_nxt = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (mul_done) begin
          state_nxt = ST_MISSUE;
          case (op_r)
            OP_P: begin
              pterm_nxt = mul_res;
              op_nxt    = OP_I1;
            end
            OP_I1: begin
              tmp_nxt = mul_res;
              op_nxt  = OP_I2;
            end
            OP_I2: begin
              iacc_nxt = sat_s32(sx35(acc_r) + sx35(mul_res));
              op_nxt   = OP_D;
            end
            OP_D: begin
              num_nxt = mul_res;
              if (dt_r == 31'd0) begin
                dterm_nxt = '0;
                state_nxt = ST_SUM;
              end else begin
                state_nxt = ST_DSTART;
              end
            end
            OP_C1: begin
              tmp_nxt = mul_res;
              op_nxt  = OP_C2;
            end
            OP_C2: begin
              acc_nxt   = sat_s32(sx35(iacc_r) + sx35(mul_res));
              prev_nxt  = err_r;
              state_nxt = ST_OUT;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_DSTART: begin
        div_go    = 1'b1;
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          dterm_nxt = div_q;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_nxt   = sx35(pterm_r) + sx35(iacc_r) + sx35(dterm_r);
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        drv_nxt   = sum_clamped[31:0];
        iacc_nxt  = iacc_clamped[31:0];
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        tmp_nxt   = sat_s32(sx35(drv_r) - sum_r);
        op_nxt    = OP_C1;
        state_nxt = ST_MISSUE;
      end
      ST_OUT: begin
        // Hold here until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_drive_nxt = (gated_r || !enable_r) ? 32'sd0 : drv_r;
          out_gated_nxt = gated_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and loop state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_P;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      prev_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      prev_r      <= prev_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    meas_r      <= meas_nxt;
    tgt_r       <= tgt_nxt;
    dt_r        <= dt_nxt;
    err_r       <= err_nxt;
    diff_r      <= diff_nxt;
    pterm_r     <= pterm_nxt;
    tmp_r       <= tmp_nxt;
    iacc_r      <= iacc_nxt;
    num_r       <= num_nxt;
    dterm_r     <= dterm_nxt;
    drv_r       <= drv_nxt;
    sum_r       <= sum_nxt;
    gated_r     <= gated_nxt;
    out_drive_r <= out_drive_nxt;
    out_gated_r <= out_gated_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r  <= '0;
      gain_i_r  <= '0;
      gain_d_r  <= '0;
      gain_bc_r <= '0;
      ibound_r  <= '0;
      obound_r  <= '0;
      gate_r    <= '0;
      enable_r  <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN_P:         gain_p_r  <= cfg_data;
        REG_GAIN_I:         gain_i_r  <= cfg_data;
        REG_GAIN_D:         gain_d_r  <= cfg_data;
        REG_GAIN_BACKCALC:  gain_bc_r <= cfg_data;
        REG_INTEGRAL_BOUND: ibound_r  <= cfg_data[30:0];
        REG_OUTPUT_BOUND:   obound_r  <= cfg_data[30:0];
        REG_ERROR_GATE:     gate_r    <= cfg_data[30:0];
        REG_LOOP_ENABLE:    enable_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_drive_r;
  assign out_tuser  = out_gated_r;

endmodule

FILE: rtl/pbaw_checker.sv
// Port-level checker for the PID back-calculation core, bound to the top level.
// Depends on pid_backcalc_antiwindup_core_macros.svh.
`include "pid_backcalc_antiwindup_core_macros.svh"

module pbaw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result holds
  `PBAW_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // A gated result always carries zero drive
  `PBAW_ASSERT_NOW(a_gated_zero, out_tvalid && out_tuser, out_tdata == 32'd0, "gated result with non-zero drive")

  // An accepted item keeps the input closed while the core passes through ST_ERR and ST_GATE
  `PBAW_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready ##1 !in_tready, "input reopened too early")

endmodule

bind pid_backcalc_antiwindup_core pbaw_checker u_pbaw_checker (.*);

FILE: bench/tb.sv
// Self-checking bench for pid_backcalc_antiwindup_core: directed and random control steps.
// Predicts drive and gate flag in Q16.16 alongside the core; depends on pbaw_pkg and the core.
module tb;
  import pbaw_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [30:0]        time_step;
    logic signed [31:0] target;
    logic signed [31:0] measured;
  } pid_item_t;

  typedef struct packed {
    logic [31:0] drive;
    logic        gated;
  } drive_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;  // [31:0] measured, [63:32] target, [94:64] time_step
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;      // [31:0] drive
  logic        out_tuser;      // [0] gated
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Controller settings and state as the bench sees them
  longint gain_prop = 0;
  longint gain_int = 0;
  longint gain_der = 0;
  longint gain_aw = 0;
  longint int_limit = 0;
  longint out_limit = 0;
  longint gate_level = 0;
  bit     loop_on = 1'b1;
  longint integ = 0;
  longint err_prev = 0;

  pid_item_t     pending_items[$];
  drive_result_t expected_results[$];
  pid_item_t     offered;
  drive_result_t head;
  int            errors = 0;
  int            cycle_count = 0;
  int            in_idle_pct = 22;
  int            out_idle_pct = 22;
  bit            hold_request = 1'b0;
  bit            hold_done = 1'b0;
  int            hold_left = 0;

  pid_backcalc_antiwindup_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint sat_word(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Exact product, floored back to Q16.16, saturated
  function automatic longint q_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return sat_word(p >>> 16);
  endfunction

  function automatic longint clamp_mag(input longint x, input longint bound);
    if (x > bound) return bound;
    if (x < -bound) return -bound;
    return x;
  endfunction

  // Work out the drive for one accepted item and advance the loop state
  task automatic predict_step(input pid_item_t it);
    longint meas, tgt, dt, err, mag, pterm, iacc, dterm, sum, drv, corr, num;
    drive_result_t r;
    meas = $signed(it.measured);
    tgt  = $signed(it.target);
    dt   = it.time_step;
    err  = sat_word(tgt - meas);
    mag  = (err < 0) ? -err : err;
    if (gate_level != 0 && mag > gate_level) begin
      r.drive = '0;
      r.gated = 1'b1;
      expected_results.push_back(r);
      return;
    end
    pterm = q_mul(gain_prop, err);
    iacc  = sat_word(integ + q_mul(q_mul(gain_int, err), dt));
    dterm = 0;
    if (dt != 0) begin
      num   = q_mul(gain_der, sat_word(err - err_prev));
      dterm = sat_word((num * 65536) / dt);
    end
    // Unclamped sum stays exact; back-calculation feeds the clamp error back
    sum      = pterm + iacc + dterm;
    iacc     = clamp_mag(iacc, int_limit);
    drv      = clamp_mag(sum, out_limit);
    corr     = q_mul(q_mul(sat_word(drv - sum), gain_aw), dt);
    integ    = sat_word(iacc + corr);
    err_prev = err;
    if (!loop_on) drv = 0;
    r.drive = drv[31:0];
    r.gated = 1'b0;
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    errors++;
  endtask

  // Track register writes as the core takes them
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_P:         gain_prop = $signed(cfg_data);
        REG_GAIN_I:         gain_int = $signed(cfg_data);
        REG_GAIN_D:         gain_der = $signed(cfg_data);
        REG_GAIN_BACKCALC:  gain_aw = $signed(cfg_data);
        REG_INTEGRAL_BOUND: int_limit = cfg_data[30:0];
        REG_OUTPUT_BOUND:   out_limit = cfg_data[30:0];
        REG_ERROR_GATE:     gate_level = cfg_data[30:0];
        REG_LOOP_ENABLE:    loop_on = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sender: predict on acceptance, then offer the next pending item or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_step(offered);
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          offered = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {1'b0, offered.time_step, offered.target, offered.measured};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off so the core fills up and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_request && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: check each result against the oldest expectation, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, '0);
        end else begin
          head = expected_results.pop_front();
          if (out_tdata !== head.drive) report_mismatch("drive", out_tdata, head.drive);
          if (out_tuser !== head.gated) report_mismatch("gated", {31'd0, out_tuser},
                                                        {31'd0, head.gated});
        end
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_loop(input logic [31:0] kp, input logic [31:0] ki,
                          input logic [31:0] kd, input logic [31:0] kc,
                          input logic [31:0] ib, input logic [31:0] ob,
                          input logic [31:0] gt, input logic en);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_GAIN_BACKCALC, kc);
    write_reg(REG_INTEGRAL_BOUND, ib);
    write_reg(REG_OUTPUT_BOUND, ob);
    write_reg(REG_ERROR_GATE, gt);
    write_reg(REG_LOOP_ENABLE, {31'd0, en});
  endtask

  task automatic queue_item(input logic [31:0] meas, input logic [31:0] tgt,
                            input logic [30:0] dt);
    pid_item_t it;
    it.measured  = meas;
    it.target    = tgt;
    it.time_step = dt;
    pending_items.push_back(it);
  endtask

  // Hold until every item has gone in and every result has come out
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0);
  endtask

  // Mix of extremes, modest signed values and full-range words
  function automatic logic [31:0] pick_word();
    logic [31:0] v;
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3, 4: begin
        v = $urandom_range(32'h0004_0000);
        return $urandom_range(1) ? v : -v;
      end
      default: return $urandom();
    endcase
  endfunction

  // Mostly a loop settling near a setpoint, some full-range noise
  task automatic queue_random(input int n);
    logic [31:0] base;
    base = $urandom_range(32'h0010_0000) - 32'h0008_0000;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        queue_item(pick_word(), pick_word(), 31'(pick_word()));
      end else begin
        queue_item(base + $urandom_range(32'h0002_0000) - 32'h0001_0000, base,
                   ($urandom_range(9) == 0) ? 31'd0 : 31'($urandom_range(32'h0002_0000, 1)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Settings straight out of reset
    queue_item(32'h0, 32'h0, 31'h0);
    queue_item(32'h0001_0000, 32'h0002_0000, 31'h0001_0000);
    wait_drained();

    // Modest gains, gate off: field extremes, zero and tiny time step, output clamp
    set_loop(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000,
             32'h0064_0000, 32'h0032_0000, 32'h0, 1'b1);
    queue_item(32'h0, 32'h0, 31'h0);
    queue_item(32'h0, 32'h0001_0000, 31'h0000_8000);
    queue_item(32'h0, 32'h0001_0000, 31'h0000_8000);
    queue_item(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    queue_item(32'h7FFF_FFFF, 32'h8000_0000, 31'h1);
    queue_item(32'h0, 32'h0005_0000, 31'h0);
    queue_item(32'h0, 32'hFFFD_0000, 31'h1);
    queue_item(32'h0064_0000, 32'h0, 31'h0002_0000);
    wait_drained();

    // Error gate at 10.0: at the gate, just over it, far over, under
    set_loop(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000,
             32'h0064_0000, 32'h0032_0000, 32'h000A_0000, 1'b1);
    queue_item(32'h0, 32'h000A_0000, 31'h0001_0000);
    queue_item(32'h0, 32'h000A_0001, 31'h0001_0000);
    queue_item(32'h0, 32'hFFEC_0000, 31'h0001_0000);
    queue_item(32'h0, 32'hFFF7_0000, 31'h0001_0000);
    wait_drained();

    // Loop disabled: drive forced to zero while state keeps moving
    set_loop(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000,
             32'h0064_0000, 32'h0032_0000, 32'h0, 1'b0);
    queue_item(32'h0, 32'h0003_0000, 31'h0001_0000);
    queue_item(32'h8000_0000, 32'h0, 31'h0001_0000);
    wait_drained();

    // Extreme gains and bounds; most negative error exceeds the widest gate
    set_loop(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    queue_item(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    queue_item(32'h7FFF_FFFF, 32'h8000_0000, 31'h0001_0000);
    queue_item(32'h0000_0001, 32'h0, 31'h1);
    wait_drained();

    // Random settings and items; one phase without idling, one with a long stall
    for (int ph = 0; ph < 6; ph++) begin
      set_loop(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
               pick_word(), $urandom_range(1) ? 32'h0 : pick_word(),
               $urandom_range(4) != 0);
      in_idle_pct  = (ph == 2) ? 0 : 22;
      out_idle_pct = (ph == 2) ? 0 : 22;
      if (ph == 4) hold_request = 1'b1;
      queue_random(65);
      wait_drained();
    end

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
